// ===== rtl/bfa_pkg.sv =====
// Shared types, sizing constants and helper functions for the bitmap frame allocator.
// Used by bfa_out_buf and the core in rtl/; has no dependencies of its own.
`timescale 1ns / 1ps

package bfa_pkg;

    // Sizing of the frame space and the free map
    localparam int FRAMES          = 65536;
    localparam int RESERVED_FRAMES = 512;
    localparam int WORD_W          = 64;
    localparam int BIT_W           = 6;
    localparam int MAP_WORDS       = (FRAMES + WORD_W - 1) / WORD_W;
    localparam int MAP_AW          = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FNUM_W          = MAP_AW + BIT_W;
    localparam int HINT_W          = $clog2(FRAMES + 1);
    localparam int SCN_W           = MAP_AW + 1;

    // Field widths of the words on the ports
    localparam int ADDR_W      = 40;
    localparam int FRAME_SHIFT = 12;
    localparam int PFN_W       = ADDR_W - FRAME_SHIFT;
    localparam int FADDR_W     = 28;
    localparam int CNT_W       = 17;

    localparam logic [CNT_W-1:0] FREE_RESET =
        (RESERVED_FRAMES < FRAMES) ? CNT_W'(FRAMES - RESERVED_FRAMES) : '0;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_ALLOC   = 2'd0,
        ST_OOM     = 2'd1,
        ST_FREED   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef struct packed
    {
        op_t               op;
        logic [ADDR_W-1:0] phys_addr;
    } in_word_t;

    typedef struct packed
    {
        status_t            status;
        logic [FADDR_W-1:0] frame_addr;
        logic [CNT_W-1:0]   free_count;
    } out_word_t;

    // Reset contents of one map word: free for frames in [RESERVED_FRAMES, FRAMES)
    function automatic logic [WORD_W-1:0] init_word(input logic [MAP_AW-1:0] idx);
        logic [WORD_W-1:0] w;
        logic [FNUM_W-1:0] f;
        w = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            f    = {idx, BIT_W'(b)};
            w[b] = (int'(f) >= RESERVED_FRAMES) && (int'(f) < FRAMES);
        end
        return w;
    endfunction

    // Index of the lowest byte that holds a set bit
    function automatic logic [2:0] low_byte(input logic [WORD_W-1:0] w);
        logic [2:0] idx;
        idx = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (|w[i*8 +: 8])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // Index of the lowest set bit within one byte
    function automatic logic [2:0] low_bit8(input logic [7:0] v);
        logic [2:0] idx;
        idx = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/bfa_map_ram.sv =====
// Single-port-write, single-port-read synchronous RAM holding the free map.
// Registered read data; no package dependencies.
`timescale 1ns / 1ps

module bfa_map_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bfa_out_buf.sv =====
// One-entry output register for result words; decouples the result side from the core.
// Depends on bfa_pkg for the result word type.
`timescale 1ns / 1ps

module bfa_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  bfa_pkg::out_word_t load_data,
    output logic               can_load,
    output logic               valid,
    input  logic               ready,
    output bfa_pkg::out_word_t data
);

    logic               valid_reg;
    logic               valid_next;
    bfa_pkg::out_word_t data_reg;

    // Take a new word when empty or when the held one leaves this cycle
    assign can_load   = !valid_reg || ready;
    assign valid_next = load ? 1'b1 : (ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== rtl/bitmap_frame_allocator_core.sv =====
// Top level of the bitmap frame allocator: control sequencer, free-map RAM and result register.
// Depends on bfa_pkg, bfa_map_ram and bfa_out_buf.
`timescale 1ns / 1ps

// Page-frame allocator over a free map of 64-bit words held in one synchronous RAM
// (a 1 bit marks a free frame). After reset the block runs an initialization pass
// over all MAP_WORDS words (1024 at the default size) that writes the reset pattern
// into the RAM, with the first RESERVED_FRAMES frames in use; in_ready stays low
// meanwhile. An allocate word reads map words from the one that holds the search
// hint upward, one RAM read per cycle while the word read the cycle before is
// checked, takes the lowest free bit of the first nonzero word, writes the word back
// and moves the hint past that frame, then loads the result word into the output
// register. When every word from the hint word up is empty, the result is out of
// memory. A free word reads and checks the one map word, writes it back with the
// frame's bit set unless that frame was already free, then loads the result. A free
// out of range, or an allocate with the hint past the last word, goes straight to
// the result state. Items are handled one at a time; the next input word is accepted
// from the cycle after the result is loaded, while the previous result still waits
// in the output register; a full output register holds the sequencer and stalls the
// input.
module bitmap_frame_allocator_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bfa_pkg::in_word_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bfa_pkg::out_word_t out_data
);

    typedef enum logic [6:0]
    {
        S_INIT     = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_FOUND    = 7'b0001000,
        S_FREE_RD  = 7'b0010000,
        S_FREE_CHK = 7'b0100000,
        S_RESULT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Control state
    logic [bfa_pkg::MAP_AW-1:0] init_reg;
    logic [bfa_pkg::MAP_AW-1:0] init_next;
    logic [bfa_pkg::HINT_W-1:0] hint_reg;
    logic [bfa_pkg::HINT_W-1:0] hint_next;
    logic [bfa_pkg::CNT_W-1:0]  count_reg;
    logic [bfa_pkg::CNT_W-1:0]  count_next;
    logic                       pend_valid_reg;
    logic                       pend_valid_next;

    // Working registers
    logic [bfa_pkg::SCN_W-1:0]  scan_reg;
    logic [bfa_pkg::SCN_W-1:0]  scan_next;
    logic [bfa_pkg::MAP_AW-1:0] pend_addr_reg;
    logic [bfa_pkg::MAP_AW-1:0] pend_addr_next;
    logic [bfa_pkg::FNUM_W-1:0] free_frame_reg;
    logic [bfa_pkg::FNUM_W-1:0] free_frame_next;
    bfa_pkg::out_word_t         res_reg;
    bfa_pkg::out_word_t         res_next;

    // RAM port signals
    logic                       ram_we;
    logic [bfa_pkg::MAP_AW-1:0] ram_waddr;
    logic [bfa_pkg::WORD_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [bfa_pkg::MAP_AW-1:0] ram_raddr;
    logic [bfa_pkg::WORD_W-1:0] ram_rdata;

    logic                       buf_can_load;
    logic                       res_load;

    // Datapath helpers
    logic [bfa_pkg::PFN_W-1:0]  in_pfn;
    logic [bfa_pkg::HINT_W-1:0] start_word;
    logic [2:0]                 byte_idx;
    logic [2:0]                 bit_idx;
    logic [bfa_pkg::BIT_W-1:0]  found_bit;
    logic [bfa_pkg::FNUM_W-1:0] found_frame;
    logic [bfa_pkg::BIT_W-1:0]  free_bit;
    logic [bfa_pkg::CNT_W-1:0]  count_dec;
    logic [bfa_pkg::CNT_W-1:0]  count_inc;

    assign in_pfn      = in_data.phys_addr[bfa_pkg::ADDR_W-1:bfa_pkg::FRAME_SHIFT];
    assign start_word  = hint_reg >> bfa_pkg::BIT_W;
    assign byte_idx    = bfa_pkg::low_byte(ram_rdata);
    assign bit_idx     = bfa_pkg::low_bit8(ram_rdata[{byte_idx, 3'b000} +: 8]);
    assign found_bit   = {byte_idx, bit_idx};
    assign found_frame = {pend_addr_reg, found_bit};
    assign free_bit    = free_frame_reg[bfa_pkg::BIT_W-1:0];
    assign count_dec   = count_reg - bfa_pkg::CNT_W'(1);
    assign count_inc   = count_reg + bfa_pkg::CNT_W'(1);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        hint_next       = hint_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        scan_next       = scan_reg;
        pend_addr_next  = pend_addr_reg;
        free_frame_next = free_frame_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        res_load        = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                // Write the reset pattern, one word per cycle
                ram_we    = 1'b1;
                ram_waddr = init_reg;
                ram_wdata = bfa_pkg::init_word(init_reg);
                if (init_reg == bfa_pkg::MAP_AW'(bfa_pkg::MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_next = init_reg + bfa_pkg::MAP_AW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.op == bfa_pkg::OP_FREE)
                    begin
                        if (in_pfn < bfa_pkg::PFN_W'(bfa_pkg::FRAMES))
                        begin
                            free_frame_next = in_pfn[bfa_pkg::FNUM_W-1:0];
                            state_next      = S_FREE_RD;
                        end
                        else
                        begin
                            res_next.status     = bfa_pkg::ST_IGNORED;
                            res_next.frame_addr = '0;
                            res_next.free_count = count_reg;
                            state_next          = S_RESULT;
                        end
                    end
                    else if (start_word < bfa_pkg::HINT_W'(bfa_pkg::MAP_WORDS))
                    begin
                        scan_next       = bfa_pkg::SCN_W'(start_word);
                        pend_valid_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        // Hint past the last word: nothing left to search
                        res_next.status     = bfa_pkg::ST_OOM;
                        res_next.frame_addr = '0;
                        res_next.free_count = count_reg;
                        state_next          = S_RESULT;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read per cycle; check the word read the cycle before
                if (pend_valid_reg && (ram_rdata != '0))
                begin
                    pend_valid_next = 1'b0;
                    state_next      = S_FOUND;
                end
                else if (pend_valid_reg &&
                         (pend_addr_reg == bfa_pkg::MAP_AW'(bfa_pkg::MAP_WORDS - 1)))
                begin
                    pend_valid_next     = 1'b0;
                    res_next.status     = bfa_pkg::ST_OOM;
                    res_next.frame_addr = '0;
                    res_next.free_count = count_reg;
                    state_next          = S_RESULT;
                end
                else
                begin
                    pend_valid_next = (scan_reg < bfa_pkg::SCN_W'(bfa_pkg::MAP_WORDS));
                    if (scan_reg < bfa_pkg::SCN_W'(bfa_pkg::MAP_WORDS))
                    begin
                        ram_re         = 1'b1;
                        ram_raddr      = scan_reg[bfa_pkg::MAP_AW-1:0];
                        pend_addr_next = scan_reg[bfa_pkg::MAP_AW-1:0];
                        scan_next      = scan_reg + bfa_pkg::SCN_W'(1);
                    end
                end
            end

            S_FOUND:
            begin
                // Read data still holds the hit word; clear its lowest free bit
                ram_we              = 1'b1;
                ram_waddr           = pend_addr_reg;
                ram_wdata           = ram_rdata & ~(bfa_pkg::WORD_W'(1) << found_bit);
                hint_next           = bfa_pkg::HINT_W'({1'b0, found_frame} +
                                                       (bfa_pkg::FNUM_W + 1)'(1));
                count_next          = count_dec;
                res_next.status     = bfa_pkg::ST_ALLOC;
                res_next.frame_addr = bfa_pkg::FADDR_W'({found_frame,
                                                         bfa_pkg::FRAME_SHIFT'(0)});
                res_next.free_count = count_dec;
                state_next          = S_RESULT;
            end

            S_FREE_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = free_frame_reg[bfa_pkg::FNUM_W-1:bfa_pkg::BIT_W];
                state_next = S_FREE_CHK;
            end

            S_FREE_CHK:
            begin
                res_next.frame_addr = '0;
                if (!ram_rdata[free_bit])
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = free_frame_reg[bfa_pkg::FNUM_W-1:bfa_pkg::BIT_W];
                    ram_wdata           = ram_rdata | (bfa_pkg::WORD_W'(1) << free_bit);
                    count_next          = count_inc;
                    res_next.status     = bfa_pkg::ST_FREED;
                    res_next.free_count = count_inc;
                end
                else
                begin
                    res_next.status     = bfa_pkg::ST_IGNORED;
                    res_next.free_count = count_reg;
                end
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                // Hold until the output register can take the word
                if (buf_can_load)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            init_reg       <= '0;
            hint_reg       <= '0;
            count_reg      <= bfa_pkg::FREE_RESET;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_reg       <= init_next;
            hint_reg       <= hint_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        pend_addr_reg  <= pend_addr_next;
        free_frame_reg <= free_frame_next;
        res_reg        <= res_next;
    end

    bfa_map_ram #(
        .WIDTH (bfa_pkg::WORD_W),
        .DEPTH (bfa_pkg::MAP_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfa_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .load_data (res_reg),
        .can_load  (buf_can_load),
        .valid     (out_valid),
        .ready     (out_ready),
        .data      (out_data)
    );

endmodule
